>>> sv/v4mmn_pkg.sv
package v4mmn_pkg;

    localparam int MaxSamples = 64;
    localparam int NumComps   = 4;
    localparam int CompW      = 32;
    localparam int NormW      = 16;
    localparam int IndexW     = 6;
    localparam int DivSteps   = NormW;

    localparam int IdxW  = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
    localparam int CntW  = $clog2(MaxSamples + 1);
    localparam int StepW = $clog2(DivSteps);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

>>> sv/v4mmn_div.sv
module v4mmn_div (
    input  logic                                       aclk,
    input  v4mmn_pkg::div_ctl_t                        ctl,
    input  logic [v4mmn_pkg::CompW-1:0]                num [v4mmn_pkg::NumComps],
    input  logic [v4mmn_pkg::CompW-1:0]                den [v4mmn_pkg::NumComps],
    output logic [v4mmn_pkg::NormW-1:0]                quo [v4mmn_pkg::NumComps]
);

    logic [v4mmn_pkg::CompW-1:0] rem_reg  [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::CompW-1:0] rem_next [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::CompW-1:0] den_reg  [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::NormW-1:0] q_reg    [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::NormW-1:0] q_next   [v4mmn_pkg::NumComps];
    logic                        sat_reg  [v4mmn_pkg::NumComps];
    logic                        zero_reg [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::CompW:0]   shifted  [v4mmn_pkg::NumComps];
    logic                        fits     [v4mmn_pkg::NumComps];

    // one restoring step per lane: shift, compare, subtract
    always_comb begin
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            shifted[c]  = {rem_reg[c], 1'b0};
            fits[c]     = shifted[c] >= {1'b0, den_reg[c]};
            rem_next[c] = fits[c] ? v4mmn_pkg::CompW'(shifted[c] - {1'b0, den_reg[c]})
                                  : v4mmn_pkg::CompW'(shifted[c]);
            q_next[c]   = {q_reg[c][v4mmn_pkg::NormW-2:0], fits[c]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            if (ctl.load) begin
                // saturation flag: num equals den; the output then reads as all ones unless den is zero
                sat_reg[c]  <= (num[c] == den[c]);
                zero_reg[c] <= (den[c] == '0);
                rem_reg[c]  <= (num[c] == den[c]) ? '0 : num[c];
                den_reg[c]  <= den[c];
                q_reg[c]    <= '0;
            end else if (ctl.step) begin
                rem_reg[c] <= rem_next[c];
                q_reg[c]   <= q_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            if (zero_reg[c]) begin
                quo[c] = '0;
            end else if (sat_reg[c]) begin
                quo[c] = '1;
            end else begin
                quo[c] = q_reg[c];
            end
        end
    end

endmodule

>>> sv/vec4_min_max_normalizer.sv
// vec4_min_max_normalizer
// input channel s_*: one request is a sample of four signed Q16.16
// components plus s_last_sample. samples are stored (up to 64) while the
// per-component max and min are tracked. samples beyond the store size are
// dropped and m_overflowed is set for the whole set.
// a request with s_last_sample high starts emission: s_ready drops and one
// result per stored sample leaves on the m_* channel in load order, each
// component (max - x) / (max - min) as unsigned Q0.16, zero where the
// range is zero. m_last_result marks the final result of the set.
// a result is offered after the last request or the previous result is
// taken, once the block has done a store read, a setup step and 16 steps
// of the shared four-lane restoring divider; the next sample is not read
// until the previous result is taken. when m_ready is low the result holds
// on the port and the block waits. after the last result is taken s_ready
// returns and a new set begins.
// aresetn (synchronous, active low) empties the set and returns to loading.
module vec4_min_max_normalizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_x,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_y,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_z,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_w,
    input  logic                                s_last_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [v4mmn_pkg::NormW-1:0]         m_norm_x,
    output logic [v4mmn_pkg::NormW-1:0]         m_norm_y,
    output logic [v4mmn_pkg::NormW-1:0]         m_norm_z,
    output logic [v4mmn_pkg::NormW-1:0]         m_norm_w,
    output logic [v4mmn_pkg::IndexW-1:0]        m_sample_index,
    output logic                                m_overflowed,
    output logic                                m_last_result
);

    v4mmn_pkg::state_t state_reg, state_next;

    logic [v4mmn_pkg::CntW-1:0]  count_reg, count_next;
    logic                        drop_reg, drop_next;
    logic [v4mmn_pkg::CntW-1:0]  emit_idx_reg, emit_idx_next, emit_idx_inc;
    logic [v4mmn_pkg::StepW-1:0] step_cnt_reg, step_cnt_next;

    logic signed [v4mmn_pkg::CompW-1:0] max_reg  [v4mmn_pkg::NumComps];
    logic signed [v4mmn_pkg::CompW-1:0] max_next [v4mmn_pkg::NumComps];
    logic signed [v4mmn_pkg::CompW-1:0] min_reg  [v4mmn_pkg::NumComps];
    logic signed [v4mmn_pkg::CompW-1:0] min_next [v4mmn_pkg::NumComps];
    logic signed [v4mmn_pkg::CompW-1:0] in_comp  [v4mmn_pkg::NumComps];

    logic [v4mmn_pkg::NumComps*v4mmn_pkg::CompW-1:0] sample_store [v4mmn_pkg::MaxSamples];
    logic [v4mmn_pkg::NumComps*v4mmn_pkg::CompW-1:0] rd_data_reg;

    logic [v4mmn_pkg::CompW-1:0] div_num [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::CompW-1:0] div_den [v4mmn_pkg::NumComps];
    logic [v4mmn_pkg::NormW-1:0] div_quo [v4mmn_pkg::NumComps];
    v4mmn_pkg::div_ctl_t         div_ctl;

    logic in_fire, out_fire, has_room, is_last_out, step_done;

    assign in_comp[0] = s_comp_x;
    assign in_comp[1] = s_comp_y;
    assign in_comp[2] = s_comp_z;
    assign in_comp[3] = s_comp_w;

    assign in_fire      = s_valid && s_ready;
    assign out_fire     = m_valid && m_ready;
    assign has_room     = count_reg < v4mmn_pkg::CntW'(v4mmn_pkg::MaxSamples);
    assign emit_idx_inc = emit_idx_reg + v4mmn_pkg::CntW'(1);
    assign is_last_out  = emit_idx_inc == count_reg;
    assign step_done    = step_cnt_reg == v4mmn_pkg::StepW'(v4mmn_pkg::DivSteps - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            v4mmn_pkg::ST_LOAD: begin
                if (in_fire && s_last_sample) begin
                    state_next = v4mmn_pkg::ST_READ;
                end
            end
            v4mmn_pkg::ST_READ:  state_next = v4mmn_pkg::ST_SETUP;
            v4mmn_pkg::ST_SETUP: state_next = v4mmn_pkg::ST_DIV;
            v4mmn_pkg::ST_DIV: begin
                if (step_done) begin
                    state_next = v4mmn_pkg::ST_OUT;
                end
            end
            v4mmn_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = is_last_out ? v4mmn_pkg::ST_LOAD : v4mmn_pkg::ST_READ;
                end
            end
            default: state_next = v4mmn_pkg::ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        div_ctl.load = 1'b0;
        div_ctl.step = 1'b0;
        unique case (state_reg)
            v4mmn_pkg::ST_LOAD:  s_ready = 1'b1;
            v4mmn_pkg::ST_READ:  ;
            v4mmn_pkg::ST_SETUP: div_ctl.load = 1'b1;
            v4mmn_pkg::ST_DIV:   div_ctl.step = 1'b1;
            v4mmn_pkg::ST_OUT:   m_valid = 1'b1;
            default: ;
        endcase
    end

    // set bookkeeping
    always_comb begin
        count_next    = count_reg;
        drop_next     = drop_reg;
        emit_idx_next = emit_idx_reg;
        step_cnt_next = step_cnt_reg;
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            max_next[c] = max_reg[c];
            min_next[c] = min_reg[c];
        end
        if (in_fire) begin
            if (has_room) begin
                count_next = count_reg + v4mmn_pkg::CntW'(1);
                for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
                    if (count_reg == '0 || in_comp[c] > max_reg[c]) begin
                        max_next[c] = in_comp[c];
                    end
                    if (count_reg == '0 || in_comp[c] < min_reg[c]) begin
                        min_next[c] = in_comp[c];
                    end
                end
            end else begin
                drop_next = 1'b1;
            end
            emit_idx_next = '0;
        end
        if (div_ctl.load) begin
            step_cnt_next = '0;
        end else if (div_ctl.step) begin
            step_cnt_next = step_cnt_reg + v4mmn_pkg::StepW'(1);
        end
        if (out_fire) begin
            emit_idx_next = emit_idx_inc;
            if (is_last_out) begin
                count_next = '0;
                drop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= v4mmn_pkg::ST_LOAD;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            emit_idx_reg <= '0;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            drop_reg     <= drop_next;
            emit_idx_reg <= emit_idx_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            max_reg[c] <= max_next[c];
            min_reg[c] <= min_next[c];
        end
    end

    // sample store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (in_fire && has_room) begin
            sample_store[count_reg[v4mmn_pkg::IdxW-1:0]] <=
                {s_comp_w, s_comp_z, s_comp_y, s_comp_x};
        end
        rd_data_reg <= sample_store[emit_idx_reg[v4mmn_pkg::IdxW-1:0]];
    end

    always_comb begin
        for (int c = 0; c < v4mmn_pkg::NumComps; c++) begin
            div_num[c] = v4mmn_pkg::CompW'(max_reg[c]
                         - rd_data_reg[c*v4mmn_pkg::CompW +: v4mmn_pkg::CompW]);
            div_den[c] = v4mmn_pkg::CompW'(max_reg[c] - min_reg[c]);
        end
    end

    v4mmn_div u_div (
        .aclk (aclk),
        .ctl  (div_ctl),
        .num  (div_num),
        .den  (div_den),
        .quo  (div_quo)
    );

    assign m_norm_x       = div_quo[0];
    assign m_norm_y       = div_quo[1];
    assign m_norm_z       = div_quo[2];
    assign m_norm_w       = div_quo[3];
    assign m_sample_index = v4mmn_pkg::IndexW'(emit_idx_reg);
    assign m_overflowed   = drop_reg;
    assign m_last_result  = is_last_out;

endmodule

>>> sv/v4mmn_chk.sv
module v4mmn_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_last_sample,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [v4mmn_pkg::NormW-1:0]        m_norm_x,
    input logic [v4mmn_pkg::IndexW-1:0]       m_sample_index,
    input logic                               m_last_result
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid high together");

    // a last sample ends loading
    a_last_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_sample) |=> !s_ready)
        else $error("still loading after last sample");

    // a plain sample keeps loading
    a_plain_keeps_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last_sample) |=> s_ready)
        else $error("loading stopped without last sample");

    // final result returns to loading
    a_last_result_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> s_ready)
        else $error("not loading after last result");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_norm_x)
                                   && $stable(m_sample_index)))
        else $error("stalled result changed");

endmodule

bind vec4_min_max_normalizer v4mmn_chk u_v4mmn_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_sample  (s_last_sample),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_norm_x       (m_norm_x),
    .m_sample_index (m_sample_index),
    .m_last_result  (m_last_result)
);

>>> bench/v4mmn_checker.sv
module v4mmn_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_x,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_y,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_z,
    input  logic signed [v4mmn_pkg::CompW-1:0]  s_comp_w,
    input  logic                                s_last_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [v4mmn_pkg::NormW-1:0]         m_norm_x,
    input  logic [v4mmn_pkg::NormW-1:0]         m_norm_y,
    input  logic [v4mmn_pkg::NormW-1:0]         m_norm_z,
    input  logic [v4mmn_pkg::NormW-1:0]         m_norm_w,
    input  logic [v4mmn_pkg::IndexW-1:0]        m_sample_index,
    input  logic                                m_overflowed,
    input  logic                                m_last_result,
    output int                                  n_errors,
    output int                                  n_pending,
    output int                                  n_results,
    output int                                  n_sets,
    output int                                  n_dropped_sets
);

    localparam int MaxSamples = v4mmn_pkg::MaxSamples;
    localparam int NumComps   = v4mmn_pkg::NumComps;
    localparam int CompW      = v4mmn_pkg::CompW;
    localparam int NormW      = v4mmn_pkg::NormW;
    localparam int IndexW     = v4mmn_pkg::IndexW;
    localparam int ReportMax  = 10;

    typedef logic [NumComps-1:0][CompW-1:0] comp_vec_t;

    typedef struct packed {
        logic [NumComps-1:0][NormW-1:0] norm;
        logic [IndexW-1:0]              index;
        logic                           overflowed;
        logic                           last;
    } norm_result_t;

    comp_vec_t    sample_mem [MaxSamples];
    comp_vec_t    comp_hi;
    comp_vec_t    comp_lo;
    int           fill;
    logic         dropped;
    norm_result_t norm_q [$];

    int err_cnt;
    int result_cnt;
    int set_cnt;
    int drop_set_cnt;

    function automatic logic [NormW-1:0] scaled_distance(
        input logic [CompW-1:0] x,
        input logic [CompW-1:0] hi,
        input logic [CompW-1:0] lo
    );
        longint gap;
        longint span;
        longint q;
        gap  = longint'($signed(hi)) - longint'($signed(x));
        span = longint'($signed(hi)) - longint'($signed(lo));
        if (span == 0) begin
            return '0;
        end
        q = (gap <<< NormW) / span;
        if (q > 65535) begin
            q = 65535;
        end
        return q[NormW-1:0];
    endfunction

    task automatic absorb_sample(input comp_vec_t v, input logic lst);
        norm_result_t r;
        int           k;
        int           c;
        if (fill < MaxSamples) begin
            sample_mem[fill] = v;
            for (c = 0; c < NumComps; c++) begin
                if (fill == 0 || $signed(v[c]) > $signed(comp_hi[c])) begin
                    comp_hi[c] = v[c];
                end
                if (fill == 0 || $signed(v[c]) < $signed(comp_lo[c])) begin
                    comp_lo[c] = v[c];
                end
            end
            fill++;
        end else begin
            dropped = 1'b1;
        end
        if (lst) begin
            set_cnt++;
            if (dropped) begin
                drop_set_cnt++;
            end
            for (k = 0; k < fill; k++) begin
                for (c = 0; c < NumComps; c++) begin
                    r.norm[c] = scaled_distance(sample_mem[k][c], comp_hi[c], comp_lo[c]);
                end
                r.index      = IndexW'(k);
                r.overflowed = dropped;
                r.last       = (k == fill - 1);
                norm_q.insert(norm_q.size(), r);
            end
            fill    = 0;
            dropped = 1'b0;
            comp_hi = '0;
            comp_lo = '0;
        end
    endtask

    task automatic check_result();
        norm_result_t want;
        norm_result_t got;
        got.norm       = {m_norm_w, m_norm_z, m_norm_y, m_norm_x};
        got.index      = m_sample_index;
        got.overflowed = m_overflowed;
        got.last       = m_last_result;
        result_cnt++;
        if (norm_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= ReportMax) begin
                $display("unexpected result: x=%h y=%h z=%h w=%h idx=%0d ovf=%b last=%b",
                         got.norm[0], got.norm[1], got.norm[2], got.norm[3],
                         got.index, got.overflowed, got.last);
            end
            return;
        end
        want = norm_q.pop_front();
        if (got.norm[0] !== want.norm[0] || got.norm[1] !== want.norm[1] ||
            got.norm[2] !== want.norm[2] || got.norm[3] !== want.norm[3] ||
            got.index !== want.index || got.overflowed !== want.overflowed ||
            got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= ReportMax) begin
                $display("mismatch on result %0d", result_cnt);
                $display("  expected x=%h y=%h z=%h w=%h idx=%0d ovf=%b last=%b",
                         want.norm[0], want.norm[1], want.norm[2], want.norm[3],
                         want.index, want.overflowed, want.last);
                $display("  actual   x=%h y=%h z=%h w=%h idx=%0d ovf=%b last=%b",
                         got.norm[0], got.norm[1], got.norm[2], got.norm[3],
                         got.index, got.overflowed, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            norm_q.delete();
            fill         = 0;
            dropped      = 1'b0;
            comp_hi      = '0;
            comp_lo      = '0;
            err_cnt      = 0;
            result_cnt   = 0;
            set_cnt      = 0;
            drop_set_cnt = 0;
        end else begin
            // results leave before a new last request can queue more
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                absorb_sample({s_comp_w, s_comp_z, s_comp_y, s_comp_x}, s_last_sample);
            end
        end
        n_errors       <= err_cnt;
        n_pending      <= norm_q.size();
        n_results      <= result_cnt;
        n_sets         <= set_cnt;
        n_dropped_sets <= drop_set_cnt;
    end

endmodule

>>> bench/vec4_min_max_normalizer_tb.sv
module vec4_min_max_normalizer_tb;

    localparam int CompW       = v4mmn_pkg::CompW;
    localparam int NormW       = v4mmn_pkg::NormW;
    localparam int IndexW      = v4mmn_pkg::IndexW;
    localparam int MaxSamples  = v4mmn_pkg::MaxSamples;
    localparam int NumComps    = v4mmn_pkg::NumComps;
    localparam int RandomItems = 220;
    localparam int DrainLimit  = 50000;
    localparam int RunLimit    = 200000;

    localparam logic [CompW-1:0] CompMin = 32'h8000_0000;
    localparam logic [CompW-1:0] CompMax = 32'h7fff_ffff;

    typedef enum int {
        SPREAD_FIXED,
        SPREAD_NARROW,
        SPREAD_WIDE,
        SPREAD_EDGES
    } spread_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [CompW-1:0]  s_comp_x = '0;
    logic signed [CompW-1:0]  s_comp_y = '0;
    logic signed [CompW-1:0]  s_comp_z = '0;
    logic signed [CompW-1:0]  s_comp_w = '0;
    logic                     s_last_sample = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [NormW-1:0]         m_norm_x;
    logic [NormW-1:0]         m_norm_y;
    logic [NormW-1:0]         m_norm_z;
    logic [NormW-1:0]         m_norm_w;
    logic [IndexW-1:0]        m_sample_index;
    logic                     m_overflowed;
    logic                     m_last_result;

    logic quiet = 1'b0;
    int   n_sent;
    int   n_errors;
    int   n_pending;
    int   n_results;
    int   n_sets;
    int   n_dropped_sets;

    vec4_min_max_normalizer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_comp_x       (s_comp_x),
        .s_comp_y       (s_comp_y),
        .s_comp_z       (s_comp_z),
        .s_comp_w       (s_comp_w),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_norm_x       (m_norm_x),
        .m_norm_y       (m_norm_y),
        .m_norm_z       (m_norm_z),
        .m_norm_w       (m_norm_w),
        .m_sample_index (m_sample_index),
        .m_overflowed   (m_overflowed),
        .m_last_result  (m_last_result)
    );

    v4mmn_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_comp_x       (s_comp_x),
        .s_comp_y       (s_comp_y),
        .s_comp_z       (s_comp_z),
        .s_comp_w       (s_comp_w),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_norm_x       (m_norm_x),
        .m_norm_y       (m_norm_y),
        .m_norm_z       (m_norm_z),
        .m_norm_w       (m_norm_w),
        .m_sample_index (m_sample_index),
        .m_overflowed   (m_overflowed),
        .m_last_result  (m_last_result),
        .n_errors       (n_errors),
        .n_pending      (n_pending),
        .n_results      (n_results),
        .n_sets         (n_sets),
        .n_dropped_sets (n_dropped_sets)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * RunLimit);
        $display("timeout with %0d results outstanding", n_pending);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls plus two long hold-offs
    initial begin
        int taken;
        int hold_left;
        int holds_done;
        taken      = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                taken++;
            end
            if (hold_left == 0 && holds_done < 2 && taken >= 30 + 120 * holds_done) begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 11);
            end
        end
    end

    task automatic send_sample(
        input logic [CompW-1:0] cx,
        input logic [CompW-1:0] cy,
        input logic [CompW-1:0] cz,
        input logic [CompW-1:0] cw,
        input logic             lst
    );
        while (!quiet && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_comp_x      <= cx;
        s_comp_y      <= cy;
        s_comp_z      <= cz;
        s_comp_w      <= cw;
        s_last_sample <= lst;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        n_sent++;
    endtask

    function automatic logic [CompW-1:0] rand_comp(input spread_t spread,
                                                   input logic [CompW-1:0] base);
        case (spread)
            SPREAD_FIXED:  return base;
            SPREAD_NARROW: return base + CompW'($urandom_range(255)) - 32'd128;
            SPREAD_WIDE:   return $urandom();
            default: begin
                case ($urandom_range(3))
                    0:       return CompMin;
                    1:       return CompMax;
                    2:       return '0;
                    default: return base;
                endcase
            end
        endcase
    endfunction

    initial begin
        spread_t          spread [NumComps];
        logic [CompW-1:0] base   [NumComps];
        logic [CompW-1:0] v      [NumComps];
        int               set_no;
        int               set_len;
        int               n_random;
        int               guard;
        int               k;
        int               c;
        int               r;

        n_sent   = 0;
        set_no   = 0;
        n_random = 0;
        guard    = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single sample: every range is zero
        send_sample('0, '0, '0, '0, 1'b1);
        // opposite extremes: full range, saturation to one
        send_sample(CompMin, CompMax, '0, 32'hffff_ffff, 1'b0);
        send_sample(CompMax, CompMin, 32'hffff_ffff, '0, 1'b1);
        // truncated fractions, one constant lane, alternating bit patterns
        send_sample(32'd0, 32'd7, 32'hffff_0000, 32'h5555_5555, 1'b0);
        send_sample(32'd1, 32'd7, 32'h0001_0000, 32'haaaa_aaaa, 1'b0);
        send_sample(32'd3, 32'd7, 32'd0, 32'd0, 1'b1);
        // repeated largest values
        send_sample(CompMax, CompMax, CompMax, CompMax, 1'b0);
        send_sample(CompMax, CompMax, CompMax, CompMax, 1'b1);
        // small ramps around zero and at the bottom of the signed range
        send_sample(32'd1, 32'hffff_ffff, CompMin, 32'h1234_5678, 1'b0);
        send_sample(32'd2, 32'hffff_fffe, CompMin + 1, 32'h1234_5679, 1'b0);
        send_sample(32'd3, 32'hffff_fffd, CompMin + 2, 32'hedcb_a987, 1'b0);
        send_sample(32'd4, 32'hffff_fffc, CompMin + 3, 32'h0000_0001, 1'b1);

        while (n_random < RandomItems) begin
            if (set_no == 3) begin
                set_len = MaxSamples;
            end else if (set_no == 8) begin
                // store full, extra requests dropped including the last
                set_len = MaxSamples + 1 + $urandom_range(4);
            end else begin
                r = $urandom_range(99);
                if (r < 80) begin
                    set_len = $urandom_range(6, 1);
                end else if (r < 95) begin
                    set_len = $urandom_range(20, 7);
                end else begin
                    set_len = $urandom_range(40, 21);
                end
            end
            for (c = 0; c < NumComps; c++) begin
                spread[c] = spread_t'($urandom_range(3));
                base[c]   = $urandom();
            end
            for (k = 0; k < set_len; k++) begin
                quiet <= (n_random >= 120 && n_random < 170);
                for (c = 0; c < NumComps; c++) begin
                    v[c] = rand_comp(spread[c], base[c]);
                end
                send_sample(v[0], v[1], v[2], v[3], k == set_len - 1);
                n_random++;
            end
            set_no++;
        end
        s_valid       <= 1'b0;
        s_last_sample <= 1'b0;
        quiet         <= 1'b0;

        do begin
            @(posedge aclk);
            guard++;
        end while (n_pending != 0 && guard < DrainLimit);
        repeat (60) @(posedge aclk);

        $display("sent %0d samples in %0d sets, %0d with dropped samples",
                 n_sent, n_sets, n_dropped_sets);
        $display("checked %0d normalized results, %0d still outstanding",
                 n_results, n_pending);
        if (n_errors == 0 && n_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
